/* rtl/vpsl_pkg.sv */
// Shared types, constants and helpers for the velocity PD slew limiter.
// No dependencies; the serial units and the top level refer to it by scoped names.
`default_nettype none

package vpsl_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEL,
    ST_RNUM,
    ST_RDIV,
    ST_DMUL,
    ST_PMUL,
    ST_POS,
    ST_SDIV,
    ST_MDIV,
    ST_FIN
  } state_t;

  // Serial multiplier: 48-bit multiplicand, 34-bit multiplier, one bit per cycle.
  localparam int MulAW    = 48;
  localparam int MulBW    = 34;
  localparam int MulPW    = MulAW + MulBW;
  localparam int MulSteps = MulBW;

  // Serial restoring divider: 54-bit dividend, 20-bit divisor, one bit per cycle.
  localparam int DivNW    = 54;
  localparam int DivDW    = 20;
  localparam int DivSteps = DivNW;

  localparam int CntW = 6;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SCALE       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LIMITS_EN   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LOWER_LIMIT = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_UPPER_LIMIT = 3'd5;

  localparam logic [31:0] PropGainReset  = 32'd39321600;
  localparam logic [31:0] DerivGainReset = 32'd1966080;

  localparam logic [21:0] RateMax    = 22'd3276800;
  localparam logic [10:0] DtermMax   = 11'd1311;
  localparam logic [19:0] UsPerS     = 20'd1000000;
  localparam logic [23:0] EncCenter  = 24'h800000;
  localparam logic [3:0]  MarginDiv  = 4'd10;
  localparam logic [12:0] DacScale   = 13'd4800;
  localparam logic [32:0] DacOffsetQ = 33'h080000000;

  // Q8.40 times integer magnitude, shifted down to Q16.16, signed and saturated.
  function automatic logic signed [31:0] sat_q40(input logic [MulPW-1:0] prod,
                                                 input logic neg);
    logic [MulPW-25:0] mag;
    logic signed [31:0] res;
    mag = prod[MulPW-1:24];
    if (neg) begin
      if (mag > (MulPW-24)'(33'h080000000)) res = 32'sh80000000;
      else res = -$signed(mag[31:0]);
    end else begin
      if (mag > (MulPW-24)'(32'h7FFFFFFF)) res = 32'sh7FFFFFFF;
      else res = $signed(mag[31:0]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/vpsl_serial_mul.sv */
// Unsigned shift-and-add multiplier that consumes one multiplier bit per cycle.
// Depends on vpsl_pkg for operand widths and the step count.
`default_nettype none

module vpsl_serial_mul (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [vpsl_pkg::MulAW-1:0]  a,
  input  wire logic [vpsl_pkg::MulBW-1:0]  b,
  output logic                             done,
  output logic [vpsl_pkg::MulPW-1:0]       prod
);

  logic [vpsl_pkg::CntW-1:0]  cnt_r;
  logic                       done_r;
  logic [vpsl_pkg::MulAW-1:0] a_r;
  logic [vpsl_pkg::MulBW-1:0] b_r;
  logic [vpsl_pkg::MulPW-1:0] acc_r;
  logic [vpsl_pkg::MulPW-1:0] acc_nxt;

  // Multiplier bits are taken MSB first, so the accumulator doubles every step.
  always_comb begin
    acc_nxt = {acc_r[vpsl_pkg::MulPW-2:0], 1'b0};
    if (b_r[vpsl_pkg::MulBW-1]) acc_nxt = acc_nxt + vpsl_pkg::MulPW'(a_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == vpsl_pkg::CntW'(1));
      if (start) cnt_r <= vpsl_pkg::CntW'(vpsl_pkg::MulSteps);
      else if (cnt_r != '0) cnt_r <= cnt_r - vpsl_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (cnt_r != '0) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[vpsl_pkg::MulBW-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

/* rtl/vpsl_serial_div.sv */
// Restoring divider that produces one quotient bit per cycle, MSB first.
// Depends on vpsl_pkg for operand widths and the step count.
`default_nettype none

module vpsl_serial_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [vpsl_pkg::DivNW-1:0]  num,
  input  wire logic [vpsl_pkg::DivDW-1:0]  den,
  output logic                             done,
  output logic [vpsl_pkg::DivNW-1:0]       quot
);

  logic [vpsl_pkg::CntW-1:0]  cnt_r;
  logic                       done_r;
  logic [vpsl_pkg::DivDW-1:0] den_r;
  logic [vpsl_pkg::DivDW-1:0] rem_r;
  logic [vpsl_pkg::DivNW-1:0] q_r;
  logic [vpsl_pkg::DivDW+1:0] trial;
  logic                       ge;

  // The dividend shifts out of q_r while quotient bits shift in behind it.
  always_comb begin
    trial = {1'b0, rem_r, q_r[vpsl_pkg::DivNW-1]} - {2'b00, den_r};
    ge    = ~trial[vpsl_pkg::DivDW+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == vpsl_pkg::CntW'(1));
      if (start) cnt_r <= vpsl_pkg::CntW'(vpsl_pkg::DivSteps);
      else if (cnt_r != '0) cnt_r <= cnt_r - vpsl_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      q_r   <= num;
    end else if (cnt_r != '0) begin
      if (ge) rem_r <= trial[vpsl_pkg::DivDW-1:0];
      else rem_r <= {rem_r[vpsl_pkg::DivDW-2:0], q_r[vpsl_pkg::DivNW-1]};
      q_r <= {q_r[vpsl_pkg::DivNW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

/* rtl/velocity_pd_slew_limiter_unit.sv */
// Velocity PD controller with slew-rate limit and soft-limit safety trip.
// One tick is accepted when the unit is idle. Five products on the bit-serial
// multiplier and three quotients on the bit-serial divider run one after another.
// A final state then loads the result beat, and the unit returns to idle before
// the next accept. The result beat sits in an output register, so a new tick can
// be accepted while it waits to be taken. Configuration writes take effect at
// once and should only be made between ticks.
// Depends on vpsl_pkg, vpsl_serial_mul and vpsl_serial_div.
`default_nettype none

module velocity_pd_slew_limiter_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [vpsl_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [vpsl_pkg::CfgDataW-1:0]   cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [31:0]              in_target_velocity,
  input  wire logic signed [31:0]              in_raw_velocity_counts,
  input  wire logic [23:0]                     in_raw_position,
  input  wire logic [19:0]                     in_elapsed_us,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [15:0]                          out_dac_code,
  output logic                                 out_safety_trip,
  output logic signed [16:0]                   out_command_current
);

  // Configuration registers.
  logic [31:0]        prop_gain_r;
  logic [31:0]        deriv_gain_r;
  logic [47:0]        scale_r;
  logic               limits_en_r;
  logic signed [31:0] lower_r;
  logic signed [31:0] upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= vpsl_pkg::PropGainReset;
      deriv_gain_r <= vpsl_pkg::DerivGainReset;
      scale_r      <= '0;
      limits_en_r  <= 1'b0;
      lower_r      <= '0;
      upper_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vpsl_pkg::CFG_PROP_GAIN:   prop_gain_r  <= cfg_data[31:0];
        vpsl_pkg::CFG_DERIV_GAIN:  deriv_gain_r <= cfg_data[31:0];
        vpsl_pkg::CFG_SCALE:       scale_r      <= cfg_data;
        vpsl_pkg::CFG_LIMITS_EN:   limits_en_r  <= cfg_data[0];
        vpsl_pkg::CFG_LOWER_LIMIT: lower_r      <= $signed(cfg_data[31:0]);
        vpsl_pkg::CFG_UPPER_LIMIT: upper_r      <= $signed(cfg_data[31:0]);
        default: ;
      endcase
    end
  end

  vpsl_pkg::state_t state_r, state_nxt;
  logic launched_r, launched_nxt;
  logic mul_start, div_start, op_done, fin_fire;
  logic mul_done, div_done;
  logic [vpsl_pkg::MulAW-1:0] mul_a;
  logic [vpsl_pkg::MulBW-1:0] mul_b;
  logic [vpsl_pkg::MulPW-1:0] mul_prod;
  logic [vpsl_pkg::DivNW-1:0] div_num, div_quot;
  logic [vpsl_pkg::DivDW-1:0] div_den;

  // Tick operands and intermediate results.
  logic signed [31:0] tgt_r, vc_r, err_r, pos_r, prev_err_r;
  logic [23:0]        rawpos_r;
  logic [19:0]        dt_r, step_r;
  logic [21:0]        rate_mag_r;
  logic               rate_neg_r;
  logic signed [11:0] dterm_r;
  logic signed [17:0] u_r, last_cmd_r;
  logic signed [33:0] margin_r;

  // Output register.
  logic               out_valid_r;
  logic [15:0]        dac_r;
  logic               trip_r;
  logic signed [16:0] cmd_r;

  // Operand magnitudes and signs.
  logic        scale_neg;
  logic [47:0] scale_mag;
  logic [31:0] vc_mag, err_mag;
  logic signed [32:0] ediff, hl;
  logic [32:0] ediff_mag, hl_mag;
  logic signed [24:0] pdiff;
  logic [23:0] pos_mag;
  logic [39:0] step_num;

  always_comb begin
    scale_neg = scale_r[47];
    scale_mag = scale_neg ? (48'd0 - scale_r) : scale_r;
    vc_mag    = vc_r[31] ? (32'd0 - $unsigned(vc_r)) : $unsigned(vc_r);
    err_mag   = err_r[31] ? (32'd0 - $unsigned(err_r)) : $unsigned(err_r);
    ediff     = {err_r[31], err_r} - {prev_err_r[31], prev_err_r};
    ediff_mag = ediff[32] ? (33'd0 - $unsigned(ediff)) : $unsigned(ediff);
    hl        = {upper_r[31], upper_r} - {lower_r[31], lower_r};
    hl_mag    = hl[32] ? (33'd0 - $unsigned(hl)) : $unsigned(hl);
    // A raw count of zero wraps to the positive end of the centred range.
    if (rawpos_r == 24'd0) pdiff = $signed({1'b0, vpsl_pkg::EncCenter});
    else pdiff = $signed({1'b0, rawpos_r}) - $signed({1'b0, vpsl_pkg::EncCenter});
    pos_mag   = pdiff[24] ? (24'd0 - $unsigned(pdiff[23:0])) : $unsigned(pdiff[23:0]);
    step_num  = {1'b0, dt_r, 19'd0} + {3'd0, dt_r, 17'd0};
  end

  always_comb begin
    mul_a   = scale_mag;
    mul_b   = vpsl_pkg::MulBW'(vc_mag);
    div_num = mul_prod[vpsl_pkg::DivNW-1:0];
    div_den = dt_r;
    case (state_r)
      vpsl_pkg::ST_RNUM: begin
        mul_a = vpsl_pkg::MulAW'(vpsl_pkg::UsPerS);
        mul_b = vpsl_pkg::MulBW'(ediff_mag);
      end
      vpsl_pkg::ST_DMUL: begin
        mul_a = vpsl_pkg::MulAW'(deriv_gain_r);
        mul_b = vpsl_pkg::MulBW'(rate_mag_r);
      end
      vpsl_pkg::ST_PMUL: begin
        mul_a = vpsl_pkg::MulAW'(prop_gain_r);
        mul_b = vpsl_pkg::MulBW'(err_mag);
      end
      vpsl_pkg::ST_POS: mul_b = vpsl_pkg::MulBW'(pos_mag);
      vpsl_pkg::ST_SDIV: begin
        div_num = vpsl_pkg::DivNW'(step_num);
        div_den = vpsl_pkg::UsPerS;
      end
      vpsl_pkg::ST_MDIV: begin
        div_num = vpsl_pkg::DivNW'(hl_mag);
        div_den = vpsl_pkg::DivDW'(vpsl_pkg::MarginDiv);
      end
      default: ;
    endcase
  end

  vpsl_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  vpsl_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Final combine: slew limit, safety zone and DAC code.
  logic signed [18:0] dlt_raw;
  logic signed [20:0] step_s, dlt;
  logic signed [17:0] u_new, u_out;
  logic signed [34:0] pos_x, lo_bound, hi_bound;
  logic               trip;
  logic signed [32:0] dac_num;

  always_comb begin
    dlt_raw = {u_r[17], u_r} - {last_cmd_r[17], last_cmd_r};
    step_s  = $signed({1'b0, step_r});
    dlt     = 21'(dlt_raw);
    if (dlt > step_s) dlt = step_s;
    else if (dlt < -step_s) dlt = -step_s;
    u_new    = last_cmd_r + 18'(dlt);
    pos_x    = 35'(pos_r);
    lo_bound = 35'(lower_r) + 35'(margin_r);
    hi_bound = 35'(upper_r) - 35'(margin_r);
    trip     = limits_en_r && ((pos_x <= lo_bound) || (pos_x >= hi_bound));
    u_out    = trip ? 18'sd0 : u_new;
    dac_num  = $signed(vpsl_pkg::DacOffsetQ)
             - 33'(u_out) * $signed({20'd0, vpsl_pkg::DacScale});
  end

  always_comb begin
    state_nxt    = state_r;
    launched_nxt = launched_r;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    op_done      = 1'b0;
    fin_fire     = 1'b0;
    in_ready     = (state_r == vpsl_pkg::ST_IDLE);
    case (state_r)
      vpsl_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = vpsl_pkg::ST_VEL;
      end
      vpsl_pkg::ST_VEL, vpsl_pkg::ST_RNUM, vpsl_pkg::ST_DMUL,
      vpsl_pkg::ST_PMUL, vpsl_pkg::ST_POS: begin
        mul_start    = !launched_r;
        launched_nxt = 1'b1;
        op_done      = launched_r && mul_done;
      end
      vpsl_pkg::ST_RDIV, vpsl_pkg::ST_SDIV, vpsl_pkg::ST_MDIV: begin
        div_start    = !launched_r;
        launched_nxt = 1'b1;
        op_done      = launched_r && div_done;
      end
      vpsl_pkg::ST_FIN: begin
        fin_fire = !out_valid_r || out_ready;
        if (fin_fire) state_nxt = vpsl_pkg::ST_IDLE;
      end
      default: state_nxt = vpsl_pkg::ST_IDLE;
    endcase
    if (op_done) begin
      launched_nxt = 1'b0;
      case (state_r)
        vpsl_pkg::ST_VEL:  state_nxt = vpsl_pkg::ST_RNUM;
        vpsl_pkg::ST_RNUM: state_nxt = vpsl_pkg::ST_RDIV;
        vpsl_pkg::ST_RDIV: state_nxt = vpsl_pkg::ST_DMUL;
        vpsl_pkg::ST_DMUL: state_nxt = vpsl_pkg::ST_PMUL;
        vpsl_pkg::ST_PMUL: state_nxt = vpsl_pkg::ST_POS;
        vpsl_pkg::ST_POS:  state_nxt = vpsl_pkg::ST_SDIV;
        vpsl_pkg::ST_SDIV: state_nxt = vpsl_pkg::ST_MDIV;
        vpsl_pkg::ST_MDIV: state_nxt = vpsl_pkg::ST_FIN;
        default:           state_nxt = vpsl_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vpsl_pkg::ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_err_r  <= '0;
      last_cmd_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
      if (fin_fire) begin
        out_valid_r <= 1'b1;
        last_cmd_r  <= u_out;
        if (!trip) prev_err_r <= err_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Intermediate captures; each is taken when its serial unit finishes.
  logic signed [32:0] err_x;
  logic signed [31:0] vel;
  logic [37:0]        dmag;
  logic [47:0]        pmag;
  logic signed [49:0] psum;
  logic signed [48:0] pterm;

  always_comb begin
    vel   = vpsl_pkg::sat_q40(mul_prod, vc_r[31] ^ scale_neg);
    err_x = {tgt_r[31], tgt_r} - {vel[31], vel};
    dmag  = mul_prod[53:16];
    pmag  = mul_prod[63:16];
    pterm = err_r[31] ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
    psum  = 50'(pterm) + 50'(dterm_r);
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tgt_r    <= in_target_velocity;
      vc_r     <= in_raw_velocity_counts;
      rawpos_r <= in_raw_position;
      dt_r     <= (in_elapsed_us == 20'd0) ? 20'd1 : in_elapsed_us;
    end
    if (op_done) begin
      case (state_r)
        vpsl_pkg::ST_VEL: begin
          if (err_x > 33'sh07FFFFFFF) err_r <= 32'sh7FFFFFFF;
          else if (err_x < -33'sh080000000) err_r <= 32'sh80000000;
          else err_r <= err_x[31:0];
        end
        vpsl_pkg::ST_RDIV: begin
          rate_neg_r <= ediff[32];
          if (div_quot > vpsl_pkg::DivNW'(vpsl_pkg::RateMax)) rate_mag_r <= vpsl_pkg::RateMax;
          else rate_mag_r <= div_quot[21:0];
        end
        vpsl_pkg::ST_DMUL: begin
          if (dmag > 38'(vpsl_pkg::DtermMax)) begin
            dterm_r <= rate_neg_r ? -$signed({1'b0, vpsl_pkg::DtermMax})
                                  : $signed({1'b0, vpsl_pkg::DtermMax});
          end else begin
            dterm_r <= rate_neg_r ? -$signed({1'b0, dmag[10:0]}) : $signed({1'b0, dmag[10:0]});
          end
        end
        vpsl_pkg::ST_PMUL: begin
          if (psum > 50'sd32768) u_r <= 18'sd32768;
          else if (psum < -50'sd32768) u_r <= -18'sd32768;
          else u_r <= psum[17:0];
        end
        vpsl_pkg::ST_POS:  pos_r  <= vpsl_pkg::sat_q40(mul_prod, pdiff[24] ^ scale_neg);
        vpsl_pkg::ST_SDIV: step_r <= div_quot[19:0];
        vpsl_pkg::ST_MDIV: begin
          margin_r <= hl[32] ? -$signed({1'b0, div_quot[32:0]}) : $signed({1'b0, div_quot[32:0]});
        end
        default: ;
      endcase
    end
    if (fin_fire) begin
      dac_r  <= dac_num[31:16];
      trip_r <= trip;
      cmd_r  <= u_out[16:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_dac_code        = dac_r;
  assign out_safety_trip     = trip_r;
  assign out_command_current = cmd_r;

endmodule

`default_nettype wire

/* rtl/vpsl_checker.sv */
// Port-level checks for velocity_pd_slew_limiter_unit, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module vpsl_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [15:0]       out_dac_code,
  input wire logic              out_safety_trip,
  input wire logic signed [16:0] out_command_current
);

  logic signed [32:0] dac_expect;
  assign dac_expect = 33'sh080000000 - 33'(out_command_current) * 33'sd4800;

  // A stalled result beat holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dac_code)
      && $stable(out_command_current))
    else $error("result beat changed while stalled");

  a_trip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_safety_trip |-> out_command_current == 17'sd0
      && out_dac_code == 16'd32768)
    else $error("safety trip without zero current");

  a_dac_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dac_code == dac_expect[31:16])
    else $error("DAC code does not match command current");

  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_command_current <= 17'sd32768
      && out_command_current >= -17'sd32768)
    else $error("command current outside half an ampere");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind velocity_pd_slew_limiter_unit vpsl_checker u_vpsl_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_dac_code        (out_dac_code),
  .out_safety_trip     (out_safety_trip),
  .out_command_current (out_command_current)
);

`default_nettype wire
